FILE: rtl/tac_pkg.sv
package tac_pkg;

  localparam int unsigned DelayW   = 24;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned OrderDef = 2;
  localparam int unsigned FracBits = 20;
  // accumulator magnitude is clamped to 2^37, so 39 signed bits hold it
  localparam int unsigned AccW     = 39;
  localparam int unsigned NumW     = 26;
  localparam int unsigned ProdW    = AccW + NumW;
  localparam int unsigned DenW     = 25;
  localparam logic [DelayW-1:0] Q16One = 24'h010000;

  typedef enum logic [2:0] {
    StIdle, StInit, StMul, StLoad, StDiv, StFin, StOut
  } state_e;

  // binomial coefficient C(n,k), n <= 8, built as a row of Pascal's triangle
  function automatic logic [7:0] binom(input logic [3:0] n, input logic [3:0] k);
    logic [7:0] row [0:8];
    for (int j = 0; j <= 8; j++) begin
      row[j] = (j == 0) ? 8'd1 : 8'd0;
    end
    for (int r = 1; r <= 8; r++) begin
      if (r <= int'(n)) begin
        for (int j = 8; j >= 1; j--) begin
          row[j] = row[j] + row[j-1];
        end
      end
    end
    return (k <= 4'd8) ? row[k] : 8'd0;
  endfunction

endpackage

FILE: rtl/thiran_allpass_coefficients_unit.sv
// Thiran allpass coefficient unit.
// Input stream (s_axis_*): one transaction carries the fractional delay D
// in unsigned Q8.16. Output stream (m_axis_*): ORDER+1 transactions, one per
// denominator coefficient a[i] in index order, tlast on i == ORDER. The
// numerator is the same list reversed.
// Each a[i] is built by i multiply / round-divide steps on one shared
// restoring divider that retires one quotient bit per cycle. A step is a
// multiply, a divider load, the quotient bits and taking the rounded
// quotient. Each coefficient adds an init, a finish and an output state,
// and a delay is accepted in the idle state. D <= 1.0 yields the identity
// with no divider steps.
// s_axis_tready is high only when the unit is idle. A stalled receiver holds
// the current coefficient in the output register until it is taken.
// Reset clears the sequencer; the unit then waits for a delay.
module thiran_allpass_coefficients_unit
  import tac_pkg::*;
#(
  parameter int unsigned ORDER = OrderDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [23:0] delay
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [3:0] coef_index, [35:4] coef_value
  output logic              m_axis_tlast    // last
);

  localparam logic [3:0] OrdV = 4'(ORDER);
  localparam logic signed [AccW-1:0] AccLim = AccW'(64'sd1 <<< 37);

  state_e state_q, state_d;
  logic [DelayW-1:0] d_q;
  logic [3:0] i_q, i_d, k_q, k_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [CoefW-1:0] val_q, val_d;
  logic ident_q, ident_d;
  logic div_start, div_busy;
  logic [ProdW-1:0] mag, quot;
  logic [DenW-1:0] den;
  logic signed [NumW-1:0] num;
  logic signed [ProdW:0] q_s;
  logic signed [AccW-1:0] fin;

  assign num = NumW'(signed'({2'b00, d_q}))
             - NumW'(signed'({1'b0, OrdV - k_q, 16'h0}));
  assign den = DenW'({1'b0, d_q}) + DenW'({k_q + 4'd1, 16'h0});
  assign mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);

  always_comb begin
    // load the divider once the product register holds this step's product
    div_start = (state_q == StLoad);
    q_s = prod_q[ProdW-1] ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    fin = i_q[0] ? -acc_q : acc_q;
  end

  tac_divider u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (mag + ProdW'(den >> 1)),
    .divisor_i  (den),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (s_axis_tvalid) state_d = StInit;
      StInit: state_d = (ident_q || i_q == 4'd0) ? StFin : StMul;
      StMul:  state_d = StLoad;
      StLoad: state_d = StDiv;
      StDiv:  if (!div_busy) state_d = (k_q + 4'd1 == i_q) ? StFin : StMul;
      StFin:  state_d = StOut;
      StOut:  if (m_axis_tready) state_d = (i_q == OrdV) ? StIdle : StInit;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    i_d = i_q; k_d = k_q; acc_d = acc_q; prod_d = prod_q; val_d = val_q;
    ident_d = ident_q;
    case (state_q)
      StIdle: begin
        i_d = '0;
        ident_d = (s_axis_tdata <= Q16One);
      end
      StInit: begin
        k_d = '0;
        acc_d = AccW'({binom(OrdV, i_q), 20'h0});
      end
      StMul: prod_d = ProdW'(acc_q) * ProdW'(num);
      StDiv: if (!div_busy) begin
        if (q_s > (ProdW + 1)'(AccLim)) acc_d = AccLim;
        else if (q_s < -(ProdW + 1)'(AccLim)) acc_d = -AccLim;
        else acc_d = AccW'(q_s);
        k_d = k_q + 4'd1;
      end
      StFin: begin
        if (ident_q) val_d = (i_q == 4'd0) ? 32'h0010_0000 : '0;
        else if (fin > AccW'(64'sd2147483647)) val_d = 32'h7fff_ffff;
        else if (fin < -AccW'(64'sd2147483648)) val_d = 32'h8000_0000;
        else val_d = CoefW'(fin);
      end
      StOut: if (m_axis_tready) i_d = i_q + 4'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) d_q <= s_axis_tdata;
    acc_q <= acc_d; prod_q <= prod_d; val_q <= val_d; ident_q <= ident_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {4'h0, val_q, i_q};
  assign m_axis_tlast  = (i_q == OrdV);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> i_q <= OrdV) else $error("index");

endmodule

FILE: rtl/tac_divider.sv
module tac_divider
  import tac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [DenW-1:0]  divisor_i,
  output logic             busy_o,
  output logic [ProdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] quot_q, quot_d;
  logic [DenW:0]    rem_q, rem_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DenW:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quot_q[ProdW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CntW'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step: one quotient bit per cycle
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule
